@@ rtl/stsum_pkg.sv @@
// Shared types and constants for the segment tree range-sum block.
`default_nettype none

package stsum_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int unsigned FUNC_W  = 1;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LENGTH_W = 11;
  localparam int unsigned SUM_W   = 64;

  // One tree node: a 64-bit two's complement partial sum.
  typedef logic [SUM_W-1:0] node_t;

  // Operation codes carried on the func port.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ASSIGN = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  // Active length after reset.
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ rtl/stsum_ram.sv @@
// Single-port-write, single-port-read node memory with a registered read.
`default_nettype none

module stsum_ram #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned ADDR_W = 11
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire  [ADDR_W-1:0]     waddr,
  input  stsum_pkg::node_t      wdata,
  input  wire                   re,
  input  wire  [ADDR_W-1:0]     raddr,
  output stsum_pkg::node_t      rdata
);
  import stsum_pkg::*;

  node_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/segment_tree_range_sum.sv @@
// Top level of the segment tree range-sum block: command decode, tree walk and results.
//
// Usage: a command is taken at a rising edge where start is high and busy is low.
// func selects an element assignment (position, new_value) or a range-sum query
// (range_low to range_high inclusive). Only queries produce a result: range_sum is
// shown for exactly one cycle with range_sum_valid high, and the receiver cannot stall.
// The active length register is written over the cfg_valid/cfg_ready channel, which
// is always ready; it should only be changed while no command is in flight.
// Busy: an assignment keeps busy high while it writes the leaf and then updates each
// tree level above it in turn, because each level needs one read of the sibling node
// from the single read port of the node memory. A query keeps busy high while it
// walks the tree: it reads up to two nodes per level through that same port, one per
// cycle. The result strobe comes in the first cycle with busy low again, where the
// next command can already be taken. An assignment outside the active length
// finishes without raising busy, and an empty query goes straight to the result
// state without reading the tree.
// Reset: after rst the block clears all 2 * LEAF_COUNT nodes, one per cycle, with
// busy high; configuration writes are still taken during that pass.
`default_nettype none

module segment_tree_range_sum #(
  parameter int unsigned LEAF_COUNT = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // Command channel.
  input  wire                                 start,
  output logic                                busy,
  input  wire  [stsum_pkg::FUNC_W-1:0]        func,
  input  wire  [stsum_pkg::INDEX_W-1:0]       position,
  input  wire  signed [stsum_pkg::VALUE_W-1:0] new_value,
  input  wire  [stsum_pkg::INDEX_W-1:0]       range_low,
  input  wire  [stsum_pkg::INDEX_W-1:0]       range_high,
  // Result channel.
  output logic                                range_sum_valid,
  output logic signed [stsum_pkg::SUM_W-1:0]  range_sum,
  // Configuration channel.
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [stsum_pkg::LENGTH_W-1:0]      cfg_data
);
  import stsum_pkg::*;

  localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT;
  localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned LEN_W      = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_LEAF,
    ST_A_UP,
    ST_Q_A,
    ST_Q_B,
    ST_Q_DONE
  } state_t;

  state_t                state;
  logic [LENGTH_W-1:0]   active_length;
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     node_k;
  node_t                 cur;
  logic [CNT_W-1:0]      qa;
  logic [CNT_W-1:0]      qb;
  node_t                 acc;
  logic                  pend;

  // Memory port signals.
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  node_t                 mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  node_t                 mem_rdata;

  // Command decode helpers.
  logic                  accept;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      len_m1;
  logic [LEN_W-1:0]      pos_ext;
  logic [LEN_W-1:0]      lo_ext;
  logic [LEN_W-1:0]      hi_ext;
  logic [LEN_W-1:0]      hi_clip;
  logic                  q_empty;
  logic [ADDR_W-1:0]     leaf_addr;
  logic [CNT_W-1:0]      qa_start;
  logic [CNT_W-1:0]      qb_start;
  logic [ADDR_W-1:0]     parent;
  logic [CNT_W-1:0]      qb_m1;
  node_t                 up_sum;
  node_t                 acc_add;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Clip the active length to the tree size and clip the query to it.
  always_comb begin
    len = (LEN_W'(active_length) > LEN_W'(LEAF_COUNT)) ? LEN_W'(LEAF_COUNT)
                                                        : LEN_W'(active_length);
    len_m1   = len - LEN_W'(1);
    pos_ext  = LEN_W'(position);
    lo_ext   = LEN_W'(range_low);
    hi_ext   = LEN_W'(range_high);
    hi_clip  = (hi_ext > len_m1) ? len_m1 : hi_ext;
    q_empty  = (len == '0) || (lo_ext >= len) || (lo_ext > hi_clip);
    leaf_addr = ADDR_W'(LEAF_COUNT) + ADDR_W'(position);
    qa_start  = CNT_W'(lo_ext) + CNT_W'(LEAF_COUNT);
    qb_start  = CNT_W'(hi_clip) + CNT_W'(LEAF_COUNT) + CNT_W'(1);
  end

  // Datapath terms for the tree walk.
  assign parent  = node_k >> 1;
  assign qb_m1   = qb - CNT_W'(1);
  assign up_sum  = cur + mem_rdata;
  assign acc_add = acc + (pend ? mem_rdata : '0);

  // Memory access for the current state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_k;
    mem_wdata = cur;
    mem_re    = 1'b0;
    mem_raddr = node_k ^ ADDR_W'(1);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_A_LEAF: begin
        mem_we    = 1'b1;
        mem_re    = 1'b1;
      end
      ST_A_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_sum;
        mem_re    = (parent > ADDR_W'(1));
        mem_raddr = parent ^ ADDR_W'(1);
      end
      ST_Q_A: begin
        mem_re    = (qa < qb) && qa[0];
        mem_raddr = qa[ADDR_W-1:0];
      end
      ST_Q_B: begin
        mem_re    = qb[0];
        mem_raddr = qb_m1[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  stsum_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_length <= cfg_data;
    end
  end

  // Sequencer: clearing pass, leaf-to-root update and bottom-up range walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      pend            <= 1'b0;
      range_sum_valid <= 1'b0;
    end else begin
      range_sum_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(NODE_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (func_t'(func) == FUNC_ASSIGN) begin
              node_k <= leaf_addr;
              cur    <= {{(SUM_W - VALUE_W){new_value[VALUE_W-1]}}, new_value};
              if (pos_ext < len) begin
                state <= ST_A_LEAF;
              end
            end else begin
              acc  <= '0;
              pend <= 1'b0;
              qa   <= qa_start;
              qb   <= qb_start;
              state <= q_empty ? ST_Q_DONE : ST_Q_A;
            end
          end
        end
        ST_A_LEAF: begin
          // The leaf is written; the sibling read is on its way.
          state <= ST_A_UP;
        end
        ST_A_UP: begin
          cur    <= up_sum;
          node_k <= parent;
          if (parent <= ADDR_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_Q_A: begin
          acc <= acc_add;
          if (qa < qb) begin
            pend <= qa[0];
            if (qa[0]) begin
              qa <= qa + CNT_W'(1);
            end
            state <= ST_Q_B;
          end else begin
            pend  <= 1'b0;
            state <= ST_Q_DONE;
          end
        end
        ST_Q_B: begin
          acc  <= acc_add;
          pend <= qb[0];
          qa   <= qa >> 1;
          qb   <= qb >> 1;
          state <= ST_Q_A;
        end
        ST_Q_DONE: begin
          range_sum       <= acc_add;
          range_sum_valid <= 1'b1;
          pend            <= 1'b0;
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/stsum_checker.sv @@
// Port-level checker for the segment tree range-sum block, with its bind statement.
`default_nettype none

module stsum_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            start,
  input wire                            busy,
  input wire [stsum_pkg::FUNC_W-1:0]    func,
  input wire                            range_sum_valid
);
  import stsum_pkg::*;

  // The clearing pass holds off commands right after reset.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy is low in the cycle after reset");

  // A result is shown only once the sequencer is back at rest.
  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    range_sum_valid |-> !busy)
    else $error("result strobe while busy");

  // No result can follow an accepted command in the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !range_sum_valid)
    else $error("result strobe right after command transaction");

  // An assignment produces no result strobe right after it is taken.
  a_assign_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_ASSIGN) |=> !range_sum_valid ##1 !range_sum_valid)
    else $error("result strobe after an assignment");

  // The result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    range_sum_valid |=> !range_sum_valid)
    else $error("result strobe held for more than one cycle");

endmodule

bind segment_tree_range_sum stsum_checker u_stsum_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .func            (func),
  .range_sum_valid (range_sum_valid)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the segment tree range-sum block: directed and random commands.
`timescale 1ns / 1ps

module tb_top;
  import stsum_pkg::*;

  localparam int unsigned LEAVES        = 1024;
  // Margin that covers the longest query busy period and its result strobe.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Run limit, well above the slowest run including the clearing pass after reset.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PHASE  = 180;

  // One command transaction as presented on the command ports.
  typedef struct {
    func_t                     func;
    logic [INDEX_W-1:0]        position;
    logic signed [VALUE_W-1:0] new_value;
    logic [INDEX_W-1:0]        range_low;
    logic [INDEX_W-1:0]        range_high;
  } tree_cmd_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [FUNC_W-1:0]          func;
  logic [INDEX_W-1:0]         position;
  logic signed [VALUE_W-1:0]  new_value;
  logic [INDEX_W-1:0]         range_low;
  logic [INDEX_W-1:0]         range_high;
  logic                       range_sum_valid;
  logic signed [SUM_W-1:0]    range_sum;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [LENGTH_W-1:0]        cfg_data;

  // Predictor state: the element values and the active length as the block should hold them.
  node_t               elem_store [LEAVES];
  logic [LENGTH_W-1:0] length_reg;
  node_t               sum_expected [$];

  int unsigned idle_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  segment_tree_range_sum u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .position        (position),
    .new_value       (new_value),
    .range_low       (range_low),
    .range_high      (range_high),
    .range_sum_valid (range_sum_valid),
    .range_sum       (range_sum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Length in effect: anything above the leaf count acts as the leaf count.
  function automatic int unsigned used_length();
    return (length_reg > LEAVES) ? LEAVES : int'(length_reg);
  endfunction

  // Apply one accepted command to the predictor and queue the sum a query must return.
  function automatic void predict_command(input tree_cmd_t c);
    int unsigned used;
    int unsigned hi;
    node_t       acc;
    used = used_length();
    if (c.func == FUNC_ASSIGN) begin
      if (c.position < used)
        elem_store[c.position] = {{(SUM_W-VALUE_W){c.new_value[VALUE_W-1]}}, c.new_value};
    end else begin
      acc = '0;
      if (used != 0 && c.range_low < used) begin
        hi = (c.range_high > used - 1) ? used - 1 : c.range_high;
        // An empty range leaves the loop untouched and the sum at zero.
        for (int unsigned i = c.range_low; i <= hi; i++)
          acc += elem_store[i];
      end
      sum_expected = {sum_expected, acc};
    end
  endfunction

  // Compare every result strobe with the oldest expected sum.
  always @(posedge clk) begin
    node_t want;
    if (!rst && range_sum_valid) begin
      if (sum_expected.size() == 0) begin
        report_mismatch($sformatf("range_sum %0d with no query pending", range_sum));
      end else begin
        want = sum_expected.pop_front();
        if (range_sum !== want)
          report_mismatch($sformatf("range_sum %0d, expected %0d", range_sum, $signed(want)));
      end
    end
  end

  // Present one command, with random idle cycles first, and wait until it is taken.
  task automatic send_command(input tree_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    func       = c.func;
    position   = c.position;
    new_value  = c.new_value;
    range_low  = c.range_low;
    range_high = c.range_high;
    do @(posedge clk); while (busy);
    predict_command(c);
  endtask

  task automatic do_assign(input int unsigned pos, input logic [VALUE_W-1:0] val);
    tree_cmd_t c;
    c.func       = FUNC_ASSIGN;
    c.position   = INDEX_W'(pos);
    c.new_value  = val;
    c.range_low  = INDEX_W'($urandom);
    c.range_high = INDEX_W'($urandom);
    send_command(c);
  endtask

  task automatic do_query(input int unsigned lo, input int unsigned hi);
    tree_cmd_t c;
    c.func       = FUNC_QUERY;
    c.position   = INDEX_W'($urandom);
    c.new_value  = $urandom;
    c.range_low  = INDEX_W'(lo);
    c.range_high = INDEX_W'(hi);
    send_command(c);
  endtask

  // Stop sending, let every pending query return, then let any assignment finish.
  task automatic wait_for_quiet();
    @(negedge clk);
    start = 1'b0;
    while (sum_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration transaction on the length register.
  task automatic write_length(input logic [LENGTH_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    length_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random command biased toward indices inside the active length.
  function automatic tree_cmd_t random_cmd();
    tree_cmd_t   c;
    int unsigned bound;
    bound = used_length();
    if (bound == 0) bound = 1;
    c.func      = ($urandom_range(1) == 0) ? FUNC_ASSIGN : FUNC_QUERY;
    c.new_value = $urandom;
    c.position  = ($urandom_range(9) < 8) ? INDEX_W'($urandom_range(bound - 1))
                                          : INDEX_W'($urandom);
    c.range_low = ($urandom_range(9) < 8) ? INDEX_W'($urandom_range(bound - 1))
                                          : INDEX_W'($urandom);
    case ($urandom_range(3))
      0: c.range_high = c.range_low + INDEX_W'($urandom_range(15));
      1: c.range_high = INDEX_W'($urandom);
      // Single-element or empty ranges; at range_low 0 or 1 the index wraps to a wide range.
      2: c.range_high = c.range_low - INDEX_W'($urandom_range(2));
      default: c.range_high = INDEX_W'($urandom_range(bound - 1));
    endcase
    return c;
  endfunction

  // The tree must read as all zero after reset; the length is written during the clearing pass.
  task automatic test_reset_clear();
    write_length(LENGTH_RESET);
    do_query(0, LEAVES - 1);
    do_query(LEAVES - 1, LEAVES - 1);
  endtask

  // Extreme values at the extreme indices, and the edge shapes of a range.
  task automatic test_extremes();
    do_assign(0, 32'h8000_0000);
    do_assign(LEAVES - 1, 32'h7FFF_FFFF);
    do_assign(511, 32'hFFFF_FFFF);
    do_assign(512, 32'h5555_5555);
    do_query(0, LEAVES - 1);
    do_query(0, 0);
    do_query(511, 512);
    do_query(700, 300);
    do_query(600, 600);
  endtask

  // Length at zero, one, above the leaf count, lowered and raised again.
  task automatic test_length_limits();
    wait_for_quiet();
    write_length(11'd1);
    do_assign(1, 32'h1234_5678);
    do_assign(0, 32'h0000_0007);
    do_query(0, LEAVES - 1);
    do_query(1, 1);
    wait_for_quiet();
    write_length(11'd0);
    do_assign(0, 32'hAAAA_AAAA);
    do_query(0, 0);
    wait_for_quiet();
    write_length(11'd2047);
    do_assign(LEAVES - 1, 32'hCAFE_0001);
    do_query(0, LEAVES - 1);
    wait_for_quiet();
    write_length(11'd100);
    do_query(0, LEAVES - 1);
    do_query(200, 300);
    wait_for_quiet();
    write_length(LENGTH_RESET);
    do_query(1020, LEAVES - 1);
  endtask

  task automatic run_random_phase(input int unsigned pct);
    idle_pct = pct;
    for (int unsigned i = 0; i < RANDOM_PHASE; i++) begin
      // Halfway through, hold off until every pending query has returned.
      if (i == RANDOM_PHASE / 2) wait_for_quiet();
      send_command(random_cmd());
    end
  endtask

  // Random traffic in three idling regimes, with a new length before each.
  task automatic test_random_traffic();
    wait_for_quiet();
    write_length(LENGTH_W'($urandom_range(1, LEAVES)));
    run_random_phase(32);
    wait_for_quiet();
    write_length(LENGTH_W'($urandom_range(0, 2047)));
    run_random_phase(78);
    wait_for_quiet();
    write_length(LENGTH_RESET);
    run_random_phase(0);
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    func        = '0;
    position    = '0;
    new_value   = '0;
    range_low   = '0;
    range_high  = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_pct    = 0;
    length_reg  = LENGTH_RESET;
    foreach (elem_store[i]) elem_store[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_clear();
    test_extremes();
    test_length_limits();
    test_random_traffic();

    wait_for_quiet();
    if (mismatches == 0 && sum_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
